### src/xbt_pkg.sv
// Shared types, constants and helper functions for the XOR bucket table update.
// Used by every module of the block; depends on nothing else.
package xbt_pkg;

    localparam int NUM_BUCKETS  = 160;
    localparam int BUCKET_W     = 8;
    localparam int SLOT_OUT_W   = 5;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_W        = 64;
    localparam int Q_DEPTH      = 2;
    localparam int IN_DATA_W    = 240;
    localparam int OUT_DATA_W   = 16;

    localparam logic [31:0] LIFETIME_RESET = 32'd3600;

    localparam logic [CFG_IDX_W-1:0] CFG_SELF_TOP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SELF_MID = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SELF_BOT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME = 3'd3;

    localparam logic [1:0] ST_IGNORED   = 2'd0;
    localparam logic [1:0] ST_REFRESHED = 2'd1;
    localparam logic [1:0] ST_INSERTED  = 2'd2;
    localparam logic [1:0] ST_DROPPED   = 2'd3;

    typedef struct packed {
        logic        valid;
        logic [63:0] id_top;
        logic [63:0] id_mid;
        logic [31:0] id_bot;
        logic [31:0] addr;
        logic [15:0] port;
        logic [31:0] expiry;
    } t_slot;

    typedef struct packed {
        logic                is_self;
        logic [BUCKET_W-1:0] bucket;
        logic [63:0]         id_top;
        logic [63:0]         id_mid;
        logic [31:0]         id_bot;
        logic [31:0]         addr;
        logic [15:0]         port;
        logic [31:0]         expiry;
    } t_job;

    typedef struct packed {
        logic [SLOT_OUT_W-1:0] slot;
        logic [BUCKET_W-1:0]   bucket;
        logic [1:0]            status;
    } t_result;

    // Position of the highest set bit, zero for a zero word.
    function automatic logic [5:0] top_bit(input logic [63:0] w);
        logic [5:0] pos;
        pos = 6'd0;
        for (int b = 0; b < 64; b++) begin
            if (w[b]) begin
                pos = 6'(b);
            end
        end
        return pos;
    endfunction

endpackage

### src/xbt_front.sv
// Front stage: registers an incoming peer record, compares it with the own id,
// picks the bucket from the XOR distance and forms the expiry. Uses xbt_pkg.
module xbt_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [63:0]         i_peer_id_top,
    input  logic [63:0]         i_peer_id_mid,
    input  logic [31:0]         i_peer_id_bot,
    input  logic [31:0]         i_peer_addr,
    input  logic [15:0]         i_peer_port,
    input  logic [31:0]         i_now_seconds,
    input  logic [63:0]         i_self_id_top,
    input  logic [63:0]         i_self_id_mid,
    input  logic [31:0]         i_self_id_bot,
    input  logic [31:0]         i_entry_lifetime,
    output logic                o_job_valid,
    output xbt_pkg::t_job       o_job,
    input  logic                i_job_ready
);
    import xbt_pkg::*;

    logic        r_valid;
    logic [63:0] r_top;
    logic [63:0] r_mid;
    logic [31:0] r_bot;
    logic [31:0] r_addr;
    logic [15:0] r_port;
    logic [31:0] r_now;

    logic [63:0] dt;
    logic [63:0] dm;
    logic [31:0] db;
    logic [BUCKET_W-1:0] bucket;

    assign o_ready = !r_valid || i_job_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_job_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_top  <= i_peer_id_top;
            r_mid  <= i_peer_id_mid;
            r_bot  <= i_peer_id_bot;
            r_addr <= i_peer_addr;
            r_port <= i_peer_port;
            r_now  <= i_now_seconds;
        end
    end

    assign dt = r_top ^ i_self_id_top;
    assign dm = r_mid ^ i_self_id_mid;
    assign db = r_bot ^ i_self_id_bot;

    // Top word maps to buckets 0-63, middle word to 64-127, bottom word to 128-159.
    always_comb begin
        if (dt != 64'd0) begin
            bucket = {2'b00, top_bit(dt)};
        end else if (dm != 64'd0) begin
            bucket = {2'b01, top_bit(dm)};
        end else begin
            bucket = {2'b10, top_bit({32'd0, db})};
        end
    end

    assign o_job_valid    = r_valid;
    assign o_job.is_self  = (dt == 64'd0) && (dm == 64'd0) && (db == 32'd0);
    assign o_job.bucket   = bucket;
    assign o_job.id_top   = r_top;
    assign o_job.id_mid   = r_mid;
    assign o_job.id_bot   = r_bot;
    assign o_job.addr     = r_addr;
    assign o_job.port     = r_port;
    assign o_job.expiry   = r_now + i_entry_lifetime;

endmodule

### src/xbt_queue.sv
// Short first-in first-out queue of classified items between front and back.
// Uses the item type and depth from xbt_pkg.
module xbt_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_ready,
    input  xbt_pkg::t_job i_job,
    output logic          o_valid,
    output xbt_pkg::t_job o_job,
    input  logic          i_pop
);
    import xbt_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_job               r_mem [Q_DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_ready = (r_cnt != CNT_W'(Q_DEPTH));
    assign o_valid = (r_cnt != CNT_W'(0));
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

### src/xbt_back.sv
// Back stage: reads one bucket row, compares all slots at once, writes the row
// back and registers the result. Holds the bucket memory. Uses xbt_pkg.
module xbt_back #(
    parameter int WAYS = 20
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_valid,
    input  xbt_pkg::t_job    i_job,
    output logic             o_job_pop,
    output logic             o_res_valid,
    output xbt_pkg::t_result o_res,
    input  logic             i_res_ready
);
    import xbt_pkg::*;

    localparam int SLOT_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam logic S_IDLE = 1'b0;
    localparam logic S_EVAL = 1'b1;

    t_slot [WAYS-1:0]    r_mem [NUM_BUCKETS];
    logic [NUM_BUCKETS-1:0] r_row_init;
    t_slot [WAYS-1:0]    r_rd_row;
    logic                r_row_ok;
    t_job                r_cur;
    logic                r_state;
    logic                r_out_valid;
    t_result             r_out;

    logic                n_out_valid;
    logic                out_free;
    logic                start;
    logic [WAYS-1:0]     vld;
    logic [WAYS-1:0]     match;
    logic                hit;
    logic                free;
    logic [SLOT_W-1:0]   hit_idx;
    logic [SLOT_W-1:0]   free_idx;
    logic [SLOT_W-1:0]   sel;
    logic                we;
    t_slot [WAYS-1:0]    n_row;
    t_slot               new_slot;
    logic [SLOT_W+SLOT_OUT_W-1:0] sel_ext;

    assign out_free  = !r_out_valid || i_res_ready;
    assign start     = (r_state == S_IDLE) && i_job_valid && out_free;
    assign o_job_pop = start;

    always_comb begin
        n_out_valid = r_out_valid && !i_res_ready;
        if ((start && i_job.is_self) || (r_state == S_EVAL)) begin
            n_out_valid = 1'b1;
        end
    end

    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            vld[i]   = r_rd_row[i].valid && r_row_ok;
            match[i] = vld[i] && (r_rd_row[i].id_top == r_cur.id_top)
                       && (r_rd_row[i].id_mid == r_cur.id_mid)
                       && (r_rd_row[i].id_bot == r_cur.id_bot);
        end
    end

    // Lowest-numbered matching slot and lowest-numbered free slot.
    always_comb begin
        hit      = 1'b0;
        free     = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit     = 1'b1;
                hit_idx = SLOT_W'(i);
            end
            if (!vld[i]) begin
                free     = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    assign sel     = hit ? hit_idx : free_idx;
    assign we      = (r_state == S_EVAL) && (hit || free);
    assign sel_ext = {SLOT_OUT_W'(0), sel};

    assign new_slot.valid  = 1'b1;
    assign new_slot.id_top = r_cur.id_top;
    assign new_slot.id_mid = r_cur.id_mid;
    assign new_slot.id_bot = r_cur.id_bot;
    assign new_slot.addr   = r_cur.addr;
    assign new_slot.port   = r_cur.port;
    assign new_slot.expiry = r_cur.expiry;

    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            if (SLOT_W'(i) == sel) begin
                n_row[i] = new_slot;
            end else begin
                n_row[i]       = r_rd_row[i];
                n_row[i].valid = vld[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[r_cur.bucket] <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_rd_row <= r_mem[i_job.bucket];
            r_cur    <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_row_init  <= '0;
            r_row_ok    <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_row_ok <= r_row_init[i_job.bucket];
                        if (!i_job.is_self) begin
                            r_state <= S_EVAL;
                        end
                    end
                end
                S_EVAL: begin
                    r_state <= S_IDLE;
                    if (we) begin
                        r_row_init[r_cur.bucket] <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && i_job.is_self) begin
            r_out.status <= ST_IGNORED;
            r_out.bucket <= '0;
            r_out.slot   <= '0;
        end else if (r_state == S_EVAL) begin
            r_out.bucket <= r_cur.bucket;
            if (hit) begin
                r_out.status <= ST_REFRESHED;
                r_out.slot   <= sel_ext[SLOT_OUT_W-1:0];
            end else if (free) begin
                r_out.status <= ST_INSERTED;
                r_out.slot   <= sel_ext[SLOT_OUT_W-1:0];
            end else begin
                r_out.status <= ST_DROPPED;
                r_out.slot   <= '0;
            end
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

### src/xor_bucket_table_update.sv
// Top level of the XOR bucket table update: configuration registers and the
// front, queue and back stages. Depends on xbt_pkg, xbt_front, xbt_queue, xbt_back.
//
// Usage: a peer record enters on the s-side stream and exactly one status item
// leaves on the m-side stream for each record, in order. The status tells
// whether the record was the own id, refreshed an entry, was inserted into a
// free slot, or was dropped because its bucket is full.
// Configuration registers (own id words and entry lifetime) are written through
// the plain write port; the user must write them only while no item is in flight,
// since the block itself does not enforce this.
// The back stage, held by the bucket memory, takes no new record until it is through
// with the last: it first reads the bucket row, then compares all slots and writes it back.
// Own id records skip the comparison and the write-back.
// Reset clears the configuration to its defaults and marks every bucket row
// as empty; the table needs no clearing pass.
// When the receiver stalls, the result stays in the output register, the
// two-entry queue fills, and then the input side deasserts its ready.
module xor_bucket_table_update #(
    parameter int WAYS = 20
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // Fields from bit 0: peer_id_top, peer_id_mid, peer_id_bot, peer_addr,
    // peer_port, now_seconds.
    input  logic [xbt_pkg::IN_DATA_W-1:0]      i_s_tdata,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // Fields from bit 0: status, bucket_index, slot_index, one zero pad bit.
    output logic [xbt_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    input  logic                               i_cfg_we,
    input  logic [xbt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [xbt_pkg::CFG_W-1:0]          i_cfg_data
);
    import xbt_pkg::*;

    logic [63:0] r_self_id_top;
    logic [63:0] r_self_id_mid;
    logic [31:0] r_self_id_bot;
    logic [31:0] r_entry_lifetime;

    logic        f_valid;
    t_job        f_job;
    logic        q_ready;
    logic        q_valid;
    t_job        q_job;
    logic        q_pop;
    t_result     res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_self_id_top    <= '0;
            r_self_id_mid    <= '0;
            r_self_id_bot    <= '0;
            r_entry_lifetime <= LIFETIME_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SELF_TOP: r_self_id_top    <= i_cfg_data;
                CFG_SELF_MID: r_self_id_mid    <= i_cfg_data;
                CFG_SELF_BOT: r_self_id_bot    <= i_cfg_data[31:0];
                CFG_LIFETIME: r_entry_lifetime <= i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    xbt_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_s_tvalid),
        .o_ready          (o_s_tready),
        .i_peer_id_top    (i_s_tdata[63:0]),
        .i_peer_id_mid    (i_s_tdata[127:64]),
        .i_peer_id_bot    (i_s_tdata[159:128]),
        .i_peer_addr      (i_s_tdata[191:160]),
        .i_peer_port      (i_s_tdata[207:192]),
        .i_now_seconds    (i_s_tdata[239:208]),
        .i_self_id_top    (r_self_id_top),
        .i_self_id_mid    (r_self_id_mid),
        .i_self_id_bot    (r_self_id_bot),
        .i_entry_lifetime (r_entry_lifetime),
        .o_job_valid      (f_valid),
        .o_job            (f_job),
        .i_job_ready      (q_ready)
    );

    xbt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .o_ready (q_ready),
        .i_job   (f_job),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_pop   (q_pop)
    );

    xbt_back #(
        .WAYS (WAYS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_job_pop   (q_pop),
        .o_res_valid (o_m_tvalid),
        .o_res       (res),
        .i_res_ready (i_m_tready)
    );

    assign o_m_tdata = {1'b0, res.slot, res.bucket, res.status};

    ast_ignored_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (res.status == ST_IGNORED)
        |-> (res.bucket == '0) && (res.slot == '0))
        else $error("own id result carries a nonzero bucket or slot");

    ast_dropped_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (res.status == ST_DROPPED) |-> (res.slot == '0))
        else $error("dropped result carries a nonzero slot");

    ast_bucket_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_valid && !q_job.is_self |-> (q_job.bucket < BUCKET_W'(NUM_BUCKETS)))
        else $error("queued item names a bucket beyond the table");

    ast_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("back stage took an item from an empty queue");

endmodule
